>>> rtl/tpfs_pkg.sv
// ----------------------------------------------------------------------------
// tpfs_pkg
// Shared types and constants for the two-class priority/FIFO scheduler.
// ----------------------------------------------------------------------------
package tpfs_pkg;

   // Field widths of the request and response beats, the costs and the csr index
   localparam int CMD_W   = 2;
   localparam int ID_W    = 16;
   localparam int SEV_W   = 4;
   localparam int STAT_W  = 3;
   localparam int TOTAL_W = 32;
   localparam int COST_W  = 8;
   localparam int CSR_IDX_W = 1;

   // Severity clamp limits and the severity reported for a regular entry
   localparam logic [SEV_W-1:0] SEV_MIN     = 4'd1;
   localparam logic [SEV_W-1:0] SEV_MAX     = 4'd10;
   localparam logic [SEV_W-1:0] SEV_REGULAR = 4'd1;

   // Cost register reset values
   localparam logic [COST_W-1:0] URGENT_COST_RST  = 8'd5;
   localparam logic [COST_W-1:0] REGULAR_COST_RST = 8'd10;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_URGENT  = 2'd0,
      CMD_ADD_REGULAR = 2'd1,
      CMD_SERVE       = 2'd2,
      CMD_REPORT      = 2'd3
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      ST_ADDED          = 3'd0,
      ST_SERVED_URGENT  = 3'd1,
      ST_SERVED_REGULAR = 3'd2,
      ST_EMPTY          = 3'd3,
      ST_FULL           = 3'd4,
      ST_REPORT         = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_URGENT_COST  = 1'b0,
      CSR_REGULAR_COST = 1'b1
   } csr_index_type;

   // Broadcast control that every cell of the sorted row sees
   typedef struct packed {
      logic             insert;
      logic             pop;
      logic [SEV_W-1:0] sev;
   } cell_ctrl_type;

endpackage

>>> rtl/tpfs_req_if.sv
// ----------------------------------------------------------------------------
// tpfs_req_if
// Request channel: valid/ready handshake with command, id and severity.
// ----------------------------------------------------------------------------
interface tpfs_req_if import tpfs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [ID_W-1:0]  entry_id;
   logic [SEV_W-1:0] severity;

   modport source (output valid, output command, output entry_id, output severity,
                   input ready);
   modport sink   (input valid, input command, input entry_id, input severity,
                   output ready);
endinterface

>>> rtl/tpfs_rsp_if.sv
// ----------------------------------------------------------------------------
// tpfs_rsp_if
// Response channel: valid/ready handshake with status, served entry and total.
// ----------------------------------------------------------------------------
interface tpfs_rsp_if import tpfs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [ID_W-1:0]    served_id;
   logic [SEV_W-1:0]   served_severity;
   logic [TOTAL_W-1:0] total_time;

   modport source (output valid, output status, output served_id,
                   output served_severity, output total_time, input ready);
   modport sink   (input valid, input status, input served_id,
                   input served_severity, input total_time, output ready);
endinterface

>>> rtl/two_class_priority_fifo_scheduler_core.sv
// ----------------------------------------------------------------------------
// two_class_priority_fifo_scheduler_core
// Strict-priority urgent row with a regular FIFO fallback and a saturating
// service-time total.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock unless responses stall, and
// answers each with exactly one response beat through an output register; a
// new request is taken whenever that register is empty or is being drained in
// the same cycle. Urgent entries sit in a row of URGENT_DEPTH cells kept
// sorted by severity (earlier arrival first among equals): an insert places
// the entry and shifts the less urgent tail right, a serve takes the head and
// shifts the row left. Regular ids live in a RAM of REGULAR_DEPTH words whose
// registered read port supplies the served id in the response cycle. No
// clearing pass is needed after reset. Users must write the cost registers via
// the csr port only while no beat is pending; the block does not enforce it.
// ----------------------------------------------------------------------------
module two_class_priority_fifo_scheduler_core import tpfs_pkg::*; #(
   parameter int URGENT_DEPTH  = 16,
   parameter int REGULAR_DEPTH = 16,
   parameter int ID_BITS       = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   tpfs_req_if.sink             req_bus,
   tpfs_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COST_W-1:0]    csr_wdata
);

   localparam int STORE_ID_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
   localparam int PTR_W      = $clog2(REGULAR_DEPTH);
   localparam int CNT_W      = $clog2(REGULAR_DEPTH + 1);

   // ------------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------------
   logic                  accept;
   command_type           cmd;
   logic [SEV_W-1:0]      sev_clamped;
   logic [STORE_ID_W-1:0] new_id;

   logic [COST_W-1:0] urgent_cost_ff, regular_cost_ff;

   cell_ctrl_type         cell_ctrl;
   logic                  cell_after [URGENT_DEPTH];
   logic                  cell_valid [URGENT_DEPTH];
   logic [SEV_W-1:0]      cell_sev   [URGENT_DEPTH];
   logic [STORE_ID_W-1:0] cell_id    [URGENT_DEPTH];
   logic                  urg_full, urg_empty;

   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             fifo_full, fifo_empty, fifo_wr, fifo_rd;
   logic [STORE_ID_W-1:0] fifo_rd_data;

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W:0]   total_sum;
   logic [COST_W-1:0]  add_cost;
   logic               add_en;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [ID_W-1:0]   sid_ff, sid_in;
   logic [SEV_W-1:0]  ssev_ff, ssev_in;
   logic              from_fifo_ff, from_fifo_in;

   // ------------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------------
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign cmd           = command_type'(req_bus.command);
   assign new_id        = req_bus.entry_id[STORE_ID_W-1:0];

   // Clamp severity into the legal range
   always_comb begin
      sev_clamped = req_bus.severity;
      if (req_bus.severity < SEV_MIN) begin
         sev_clamped = SEV_MIN;
      end else if (req_bus.severity > SEV_MAX) begin
         sev_clamped = SEV_MAX;
      end
   end

   // ------------------------------------------------------------------------
   // Cost registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         urgent_cost_ff  <= URGENT_COST_RST;
         regular_cost_ff <= REGULAR_COST_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_URGENT_COST:  urgent_cost_ff  <= csr_wdata;
            CSR_REGULAR_COST: regular_cost_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Command handling
   // ------------------------------------------------------------------------
   assign urg_full   = cell_valid[URGENT_DEPTH-1];
   assign urg_empty  = !cell_valid[0];
   assign fifo_full  = (count_ff == CNT_W'(REGULAR_DEPTH));
   assign fifo_empty = (count_ff == '0);

   always_comb begin
      cell_ctrl.insert = 1'b0;
      cell_ctrl.pop    = 1'b0;
      cell_ctrl.sev    = sev_clamped;
      fifo_wr          = 1'b0;
      fifo_rd          = 1'b0;
      add_en           = 1'b0;
      add_cost         = urgent_cost_ff;
      status_in        = status_ff;
      sid_in           = sid_ff;
      ssev_in          = ssev_ff;
      from_fifo_in     = from_fifo_ff;
      if (accept) begin
         sid_in       = '0;
         ssev_in      = '0;
         from_fifo_in = 1'b0;
         unique case (cmd)
            CMD_ADD_URGENT: begin
               if (urg_full) begin
                  status_in = ST_FULL;
               end else begin
                  cell_ctrl.insert = 1'b1;
                  status_in        = ST_ADDED;
               end
            end
            CMD_ADD_REGULAR: begin
               if (fifo_full) begin
                  status_in = ST_FULL;
               end else begin
                  fifo_wr   = 1'b1;
                  status_in = ST_ADDED;
               end
            end
            CMD_SERVE: begin
               if (!urg_empty) begin
                  cell_ctrl.pop = 1'b1;
                  add_en        = 1'b1;
                  add_cost      = urgent_cost_ff;
                  sid_in        = ID_W'(cell_id[0]);
                  ssev_in       = cell_sev[0];
                  status_in     = ST_SERVED_URGENT;
               end else if (!fifo_empty) begin
                  fifo_rd      = 1'b1;
                  add_en       = 1'b1;
                  add_cost     = regular_cost_ff;
                  ssev_in      = SEV_REGULAR;
                  from_fifo_in = 1'b1;
                  status_in    = ST_SERVED_REGULAR;
               end else begin
                  status_in = ST_EMPTY;
               end
            end
            CMD_REPORT: begin
               status_in = ST_REPORT;
            end
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Sorted urgent row
   // ------------------------------------------------------------------------
   for (genvar gi = 0; gi < URGENT_DEPTH; gi++) begin : g_cell
      logic                  l_after, l_valid, r_valid;
      logic [SEV_W-1:0]      l_sev, r_sev;
      logic [STORE_ID_W-1:0] l_id, r_id;

      if (gi == 0) begin : g_head
         assign l_after = 1'b0;
         assign l_valid = 1'b0;
         assign l_sev   = '0;
         assign l_id    = '0;
      end else begin : g_body
         assign l_after = cell_after[gi-1];
         assign l_valid = cell_valid[gi-1];
         assign l_sev   = cell_sev[gi-1];
         assign l_id    = cell_id[gi-1];
      end

      if (gi == URGENT_DEPTH - 1) begin : g_tail
         assign r_valid = 1'b0;
         assign r_sev   = '0;
         assign r_id    = '0;
      end else begin : g_inner
         assign r_valid = cell_valid[gi+1];
         assign r_sev   = cell_sev[gi+1];
         assign r_id    = cell_id[gi+1];
      end

      tpfs_cell #(
         .STORE_ID_W (STORE_ID_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .new_id      (new_id),
         .left_after  (l_after),
         .left_valid  (l_valid),
         .left_sev    (l_sev),
         .left_id     (l_id),
         .right_valid (r_valid),
         .right_sev   (r_sev),
         .right_id    (r_id),
         .after       (cell_after[gi]),
         .valid       (cell_valid[gi]),
         .sev         (cell_sev[gi]),
         .id          (cell_id[gi])
      );
   end

   // ------------------------------------------------------------------------
   // Regular FIFO pointers and storage
   // ------------------------------------------------------------------------
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (fifo_wr) begin
         tail_in  = (tail_ff == PTR_W'(REGULAR_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (fifo_rd) begin
         head_in  = (head_ff == PTR_W'(REGULAR_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   tpfs_ram #(
      .WIDTH (STORE_ID_W),
      .DEPTH (REGULAR_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_wr),
      .wr_addr (tail_ff),
      .wr_data (new_id),
      .rd_en   (fifo_rd),
      .rd_addr (head_ff),
      .rd_data (fifo_rd_data)
   );

   // ------------------------------------------------------------------------
   // Saturating service total
   // ------------------------------------------------------------------------
   assign total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(add_cost);

   always_comb begin
      total_in = total_ff;
      if (add_en) begin
         total_in = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   // ------------------------------------------------------------------------
   // Response register
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      sid_ff       <= sid_in;
      ssev_ff      <= ssev_in;
      from_fifo_ff <= from_fifo_in;
   end

   // Total is only updated on an accepted beat, so it matches the pending beat
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = status_ff;
   assign rsp_bus.served_id       = from_fifo_ff ? ID_W'(fifo_rd_data) : sid_ff;
   assign rsp_bus.served_severity = ssev_ff;
   assign rsp_bus.total_time      = total_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_row_packed: assert property (@(posedge clock) disable iff (reset)
      cell_valid[URGENT_DEPTH-1] |-> cell_valid[0])
      else $error("urgent row has a hole at its head");

   a_fifo_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty FIFO with mismatched pointers");

   a_urgent_sev: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == ST_SERVED_URGENT) |->
      (rsp_bus.served_severity >= SEV_MIN && rsp_bus.served_severity <= SEV_MAX))
      else $error("served urgent entry with illegal severity");

   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (total_ff >= $past(total_ff)))
      else $error("service total decreased");

endmodule

>>> rtl/tpfs_ram.sv
// ----------------------------------------------------------------------------
// tpfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tpfs_cell.sv
// ----------------------------------------------------------------------------
// tpfs_cell
// One slot of the sorted urgent row: holds an entry, shifts right when a more
// urgent entry is inserted ahead of it, shifts left on pop.
// ----------------------------------------------------------------------------
module tpfs_cell import tpfs_pkg::*; #(
   parameter int STORE_ID_W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [STORE_ID_W-1:0] new_id,
   input  logic                  left_after,
   input  logic                  left_valid,
   input  logic [SEV_W-1:0]      left_sev,
   input  logic [STORE_ID_W-1:0] left_id,
   input  logic                  right_valid,
   input  logic [SEV_W-1:0]      right_sev,
   input  logic [STORE_ID_W-1:0] right_id,
   output logic                  after,
   output logic                  valid,
   output logic [SEV_W-1:0]      sev,
   output logic [STORE_ID_W-1:0] id
);

   logic                  valid_ff, valid_in;
   logic [SEV_W-1:0]      sev_ff, sev_in;
   logic [STORE_ID_W-1:0] id_ff, id_in;

   // This slot belongs behind the new entry: empty, or strictly less urgent.
   // Equal severity stays ahead, so earlier arrivals keep their place.
   assign after = !valid_ff || (sev_ff < ctrl.sev);

   // Pick the next content of the slot
   always_comb begin
      valid_in = valid_ff;
      sev_in   = sev_ff;
      id_in    = id_ff;
      if (ctrl.pop) begin
         valid_in = right_valid;
         sev_in   = right_sev;
         id_in    = right_id;
      end else if (ctrl.insert && after) begin
         if (left_after) begin
            valid_in = left_valid;
            sev_in   = left_sev;
            id_in    = left_id;
         end else begin
            valid_in = 1'b1;
            sev_in   = ctrl.sev;
            id_in    = new_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sev_ff <= sev_in;
      id_ff  <= id_in;
   end

   assign valid = valid_ff;
   assign sev   = sev_ff;
   assign id    = id_ff;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-class priority/FIFO scheduler core. A
// directed pass covers the severity clamp, the order among equal severities,
// the regular fallback, an empty serve and a report. Random phases follow,
// each with its own cost setting, command mix and choice of idling on both
// channels. Every response beat is checked against a local scheduler model.
// ----------------------------------------------------------------------------
module tb;
   import tpfs_pkg::*;

   localparam int URGENT_DEPTH  = 16;
   localparam int REGULAR_DEPTH = 16;
   localparam int ID_BITS       = 16;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 500;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } traffic_mix_type;

   typedef struct packed {
      status_type         status;
      logic [ID_W-1:0]    served_id;
      logic [SEV_W-1:0]   served_severity;
      logic [TOTAL_W-1:0] total_time;
   } sched_result_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COST_W-1:0]    csr_wdata;

   tpfs_req_if req_bus ();
   tpfs_rsp_if rsp_bus ();

   // Scheduler model state
   logic [ID_W-1:0]    urgent_ids[$];
   logic [SEV_W-1:0]   urgent_sevs[$];
   logic [ID_W-1:0]    regular_ids[$];
   logic [TOTAL_W-1:0] service_total;
   logic [COST_W-1:0]  urgent_cost;
   logic [COST_W-1:0]  regular_cost;

   sched_result_type   expected_results[$];
   sched_result_type   want_result;
   int                 error_count;
   int                 rsp_hold;
   int                 quiet_cycles;
   bit                 req_idle_on;
   bit                 rsp_idle_on;

   two_class_priority_fifo_scheduler_core #(
      .URGENT_DEPTH  (URGENT_DEPTH),
      .REGULAR_DEPTH (REGULAR_DEPTH),
      .ID_BITS       (ID_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Add a cost to the total, holding at the top
   function automatic logic [TOTAL_W-1:0] accrue_cost(input logic [TOTAL_W-1:0] total,
                                                      input logic [COST_W-1:0] cost);
      logic [TOTAL_W:0] sum;
      sum = {1'b0, total} + (TOTAL_W + 1)'(cost);
      return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
   endfunction

   // Advance the scheduler model by one request and return its response
   function automatic sched_result_type schedule_next(input command_type cmd,
                                                      input logic [ID_W-1:0] id,
                                                      input logic [SEV_W-1:0] sev);
      sched_result_type res;
      logic [SEV_W-1:0] level;
      int               best;
      int               i;
      res.status          = ST_ADDED;
      res.served_id       = '0;
      res.served_severity = '0;
      level = (sev < SEV_MIN) ? SEV_MIN : ((sev > SEV_MAX) ? SEV_MAX : sev);
      case (cmd)
         CMD_ADD_URGENT: begin
            if (urgent_ids.size() >= URGENT_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               urgent_ids.push_back(id);
               urgent_sevs.push_back(level);
            end
         end
         CMD_ADD_REGULAR: begin
            if (regular_ids.size() >= REGULAR_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               regular_ids.push_back(id);
            end
         end
         CMD_SERVE: begin
            if (urgent_ids.size() > 0) begin
               // strict compare keeps the earliest arrival among equals
               best = 0;
               for (i = 1; i < urgent_ids.size(); i++) begin
                  if (urgent_sevs[i] > urgent_sevs[best]) best = i;
               end
               res.status          = ST_SERVED_URGENT;
               res.served_id       = urgent_ids[best];
               res.served_severity = urgent_sevs[best];
               urgent_ids.delete(best);
               urgent_sevs.delete(best);
               service_total = accrue_cost(service_total, urgent_cost);
            end else if (regular_ids.size() > 0) begin
               res.status          = ST_SERVED_REGULAR;
               res.served_id       = regular_ids.pop_front();
               res.served_severity = SEV_REGULAR;
               service_total = accrue_cost(service_total, regular_cost);
            end else begin
               res.status = ST_EMPTY;
            end
         end
         default: begin
            res.status = ST_REPORT;
         end
      endcase
      res.total_time = service_total;
      return res;
   endfunction

   // Send one request beat; valid stays high when the next beat follows at once
   task automatic send_request(input command_type cmd, input logic [ID_W-1:0] id,
                               input logic [SEV_W-1:0] sev);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.entry_id <= id;
      req_bus.severity <= sev;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_results.push_back(schedule_next(cmd, id, sev));
   endtask

   // Drop valid and wait until every response has come back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both cost registers while the block is idle
   task automatic set_costs(input logic [COST_W-1:0] urgent, input logic [COST_W-1:0] regular);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_URGENT_COST;
      csr_wdata <= urgent;
      @(posedge clock);
      csr_index <= CSR_REGULAR_COST;
      csr_wdata <= regular;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      urgent_cost  = urgent;
      regular_cost = regular;
   endtask

   function automatic void check_field(input string field, input logic [TOTAL_W-1:0] want,
                                       input logic [TOTAL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endfunction

   // Check each response beat and draw the stall before the next one
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $error("response beat with no request waiting, status %0d", rsp_bus.status);
               error_count++;
            end else begin
               want_result = expected_results.pop_front();
               check_field("status", TOTAL_W'(want_result.status),
                           TOTAL_W'(rsp_bus.status));
               check_field("served_id", TOTAL_W'(want_result.served_id),
                           TOTAL_W'(rsp_bus.served_id));
               check_field("served_severity", TOTAL_W'(want_result.served_severity),
                           TOTAL_W'(rsp_bus.served_severity));
               check_field("total_time", want_result.total_time, rsp_bus.total_time);
            end
            rsp_hold = rsp_idle_on ? $urandom_range(0, 15) : 0;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_bus.ready <= (rsp_hold == 0);
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   task automatic test_empty_and_report();
      send_request(CMD_SERVE, 16'h0000, 4'd0);
      send_request(CMD_REPORT, 16'hFFFF, 4'd15);
   endtask

   task automatic test_severity_clamp();
      send_request(CMD_ADD_URGENT, 16'hFFFF, 4'd0);
      send_request(CMD_ADD_URGENT, 16'h0000, 4'd15);
      send_request(CMD_ADD_URGENT, 16'h1234, SEV_MAX);
      send_request(CMD_ADD_URGENT, 16'h00A5, SEV_MIN);
      repeat (4) send_request(CMD_SERVE, 16'h0000, 4'd0);
   endtask

   task automatic test_tie_order();
      send_request(CMD_ADD_URGENT, 16'h0001, 4'd5);
      send_request(CMD_ADD_URGENT, 16'h0002, 4'd5);
      send_request(CMD_ADD_URGENT, 16'h0003, 4'd5);
      repeat (3) send_request(CMD_SERVE, 16'hFFFF, 4'd15);
   endtask

   task automatic test_regular_fallback();
      send_request(CMD_ADD_REGULAR, 16'hFFFF, 4'd15);
      send_request(CMD_ADD_REGULAR, 16'h0000, 4'd0);
      send_request(CMD_ADD_URGENT, 16'h5A5A, 4'd7);
      repeat (4) send_request(CMD_SERVE, 16'h0000, 4'd0);
      send_request(CMD_REPORT, 16'h0000, 4'd0);
   endtask

   // Random phases, each with its own costs, command mix and idling
   task automatic test_random();
      traffic_mix_type mix;
      command_type     cmd;
      logic [SEV_W-1:0] sev;
      int              phase;
      int              count;
      int              pick;
      for (phase = 0; phase < 12; phase++) begin
         case (phase)
            0: set_costs(8'd255, 8'd255);
            1: set_costs(8'd0, 8'd0);
            2: set_costs(8'd0, 8'd255);
            3: set_costs(8'd255, 8'd0);
            default: set_costs(COST_W'($urandom_range(0, 255)),
                               COST_W'($urandom_range(0, 255)));
         endcase
         if (phase == 0) mix = MIX_FILL;
         else if (phase == 1) mix = MIX_DRAIN;
         else mix = traffic_mix_type'($urandom_range(0, 2));
         if (phase % 4 == 3) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end else begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         count = $urandom_range(80, 145);
         repeat (count) begin
            pick = $urandom_range(0, 99);
            case (mix)
               MIX_FILL: cmd = (pick < 38) ? CMD_ADD_URGENT : (pick < 75) ? CMD_ADD_REGULAR :
                               (pick < 95) ? CMD_SERVE : CMD_REPORT;
               MIX_DRAIN: cmd = (pick < 12) ? CMD_ADD_URGENT : (pick < 25) ? CMD_ADD_REGULAR :
                                (pick < 92) ? CMD_SERVE : CMD_REPORT;
               default: cmd = (pick < 25) ? CMD_ADD_URGENT : (pick < 50) ? CMD_ADD_REGULAR :
                              (pick < 90) ? CMD_SERVE : CMD_REPORT;
            endcase
            sev = ($urandom_range(0, 99) < 80) ? SEV_W'($urandom_range(1, 10)) :
                                                  SEV_W'($urandom_range(0, 15));
            send_request(cmd, ID_W'($urandom_range(0, 16'hFFFF)), sev);
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_URGENT_COST;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.command  = CMD_REPORT;
      req_bus.entry_id = '0;
      req_bus.severity = '0;
      rsp_bus.ready    = 1'b0;
      urgent_cost      = URGENT_COST_RST;
      regular_cost     = REGULAR_COST_RST;
      service_total    = '0;
      error_count      = 0;
      rsp_hold         = 0;
      quiet_cycles     = 0;
      req_idle_on      = 1'b1;
      rsp_idle_on      = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_report();
      test_severity_clamp();
      test_tie_order();
      test_regular_fallback();
      test_random();
      wait_idle();

      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
